@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ sv/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types and constants of the sha1 hash engine
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef logic [31:0] word_t;

  localparam int BLOCK_BYTES  = 64;
  localparam int BLOCK_BITS   = BLOCK_BYTES * 8;
  localparam int FILL_W       = 6;
  localparam int ROUNDS       = 80;
  localparam int RND_W        = 7;
  localparam int DIGEST_WORDS = 5;
  localparam int IDX_W        = 3;
  localparam int LEN_BYTES    = 8;
  localparam int OUT_TDATA_W  = 40;

  localparam logic [FILL_W-1:0] LEN_START = 6'd56;
  localparam logic [FILL_W-1:0] LAST_FILL = 6'd63;
  localparam logic [7:0]        PAD_BYTE  = 8'h80;
  localparam logic [63:0]       BIT_STEP  = 64'd8;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  // source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic              shift_en;
    byte_sel_t         byte_sel;
    logic [2:0]        len_idx;
    logic              count_en;
    logic              load_work;
    logic              round_en;
    logic [RND_W-1:0]  round_idx;
    logic              chain_update;
    logic              digest_load;
    logic              msg_reset;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

@@ sv/sha1_datapath.sv @@
// ----------------------------------------------------------------------------
// sha1_datapath
// block buffer, message schedule, round logic, chaining words, digest buffer
// ----------------------------------------------------------------------------
module sha1_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sha1_pkg::cmd_t                   cmd,
  output sha1_pkg::stat_t                  stat,
  input  logic [7:0]                       in_byte,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sha1_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);
  import sha1_pkg::*;

  // block buffer doubles as the 16-word schedule window, oldest word on top
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic [63:0]           bits_r, bits_nxt;
  word_t                 chain_r [DIGEST_WORDS];
  word_t                 chain_nxt [DIGEST_WORDS];
  word_t                 a_r, b_r, c_r, d_r, e_r;
  word_t                 a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  word_t                 obuf_r [DIGEST_WORDS];
  word_t                 obuf_nxt [DIGEST_WORDS];
  logic [IDX_W-1:0]      ocnt_r, ocnt_nxt;
  logic [IDX_W-1:0]      oidx_r, oidx_nxt;

  logic [7:0] len_b [LEN_BYTES];
  logic [7:0] sh_byte;
  word_t      w_t, w_mix, w_new, f_val, k_val, temp;
  logic       out_fire;

  always_comb begin
    for (int i = 0; i < LEN_BYTES; i++) begin
      len_b[i] = bits_r[63 - 8*i -: 8];
    end
  end

  always_comb begin
    case (cmd.byte_sel)
      SEL_DATA: sh_byte = in_byte;
      SEL_PAD:  sh_byte = PAD_BYTE;
      SEL_ZERO: sh_byte = 8'h00;
      SEL_LEN:  sh_byte = len_b[cmd.len_idx];
      default:  sh_byte = 8'h00;
    endcase
  end

  // schedule taps: words t, t+2, t+8, t+13 of the window
  assign w_t   = blk_r[BLOCK_BITS-1 -: 32];
  assign w_mix = blk_r[BLOCK_BITS-1-32*13 -: 32] ^ blk_r[BLOCK_BITS-1-32*8 -: 32] ^
                 blk_r[BLOCK_BITS-1-32*2 -: 32] ^ w_t;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (cmd.round_idx inside {[0:19]}) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K0;
    end else if (cmd.round_idx inside {[20:39]}) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K1;
    end else if (cmd.round_idx inside {[40:59]}) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K3;
    end
  end

  assign temp = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_t;

  assign out_fire = out_tvalid && out_tready;

  always_comb begin
    blk_nxt  = blk_r;
    bits_nxt = bits_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    e_nxt    = e_r;
    chain_nxt = chain_r;
    obuf_nxt  = obuf_r;
    ocnt_nxt  = ocnt_r;
    oidx_nxt  = oidx_r;

    if (cmd.shift_en) begin
      blk_nxt = {blk_r[BLOCK_BITS-9:0], sh_byte};
    end else if (cmd.round_en) begin
      blk_nxt = {blk_r[BLOCK_BITS-33:0], w_new};
    end

    if (cmd.count_en) begin
      bits_nxt = bits_r + BIT_STEP;
    end

    if (cmd.load_work) begin
      a_nxt = chain_r[0];
      b_nxt = chain_r[1];
      c_nxt = chain_r[2];
      d_nxt = chain_r[3];
      e_nxt = chain_r[4];
    end else if (cmd.round_en) begin
      a_nxt = temp;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end

    if (cmd.chain_update) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
      chain_nxt[4] = chain_r[4] + e_r;
    end else if (cmd.msg_reset) begin
      chain_nxt[0] = IV0;
      chain_nxt[1] = IV1;
      chain_nxt[2] = IV2;
      chain_nxt[3] = IV3;
      chain_nxt[4] = IV4;
      bits_nxt     = '0;
    end

    // digest buffer drains one word per beat
    if (cmd.digest_load) begin
      obuf_nxt = chain_r;
      ocnt_nxt = IDX_W'(DIGEST_WORDS);
      oidx_nxt = '0;
    end else if (out_fire) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        obuf_nxt[i] = obuf_r[i+1];
      end
      ocnt_nxt = ocnt_r - 1'b1;
      oidx_nxt = oidx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    e_r    <= e_nxt;
    obuf_r <= obuf_nxt;
    oidx_r <= oidx_nxt;
    if (!rst_n) begin
      bits_r     <= '0;
      chain_r[0] <= IV0;
      chain_r[1] <= IV1;
      chain_r[2] <= IV2;
      chain_r[3] <= IV3;
      chain_r[4] <= IV4;
      ocnt_r     <= '0;
    end else begin
      bits_r  <= bits_nxt;
      chain_r <= chain_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  assign out_tvalid    = (ocnt_r != '0);
  assign out_tdata     = {{(OUT_TDATA_W-32-IDX_W){1'b0}}, oidx_r, obuf_r[0]};
  assign out_tlast     = (oidx_r == IDX_W'(DIGEST_WORDS - 1));
  assign stat.out_busy = out_tvalid;

endmodule

@@ sv/sha1_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1_ctrl
// sequencer: byte fill, padding, round count, digest hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_kind,
  input  sha1_pkg::stat_t  stat,
  output sha1_pkg::cmd_t   cmd
);
  import sha1_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PAD    = 5'b00010,
    S_ROUND  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic              final_r, final_nxt;   // finish seen, padding under way
  logic              len_ok_r, len_ok_nxt; // current block carries the length

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    rnd_nxt    = rnd_r;
    final_nxt  = final_r;
    len_ok_nxt = len_ok_r;
    in_tready  = 1'b0;
    cmd        = '0;
    cmd.len_idx   = fill_r[2:0];
    cmd.round_idx = rnd_r;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.shift_en = 1'b1;
          fill_nxt     = fill_r + 1'b1;
          if (in_kind) begin
            cmd.byte_sel = SEL_PAD;
            final_nxt    = 1'b1;
            len_ok_nxt   = (fill_r < LEN_START);
          end else begin
            cmd.byte_sel = SEL_DATA;
            cmd.count_en = 1'b1;
          end
          if (fill_r == LAST_FILL) begin
            cmd.load_work = 1'b1;
            state_nxt     = S_ROUND;
          end else if (in_kind) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = (len_ok_r && fill_r >= LEN_START) ? SEL_LEN : SEL_ZERO;
        fill_nxt     = fill_r + 1'b1;
        if (fill_r == LAST_FILL) begin
          cmd.load_work = 1'b1;
          state_nxt     = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          rnd_nxt   = '0;
          state_nxt = S_UPDATE;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.chain_update = 1'b1;
        if (!final_r) begin
          state_nxt = S_IDLE;
        end else if (!len_ok_r) begin
          len_ok_nxt = 1'b1;
          state_nxt  = S_PAD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.digest_load = 1'b1;
          cmd.msg_reset   = 1'b1;
          final_nxt       = 1'b0;
          len_ok_nxt      = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      rnd_r    <= '0;
      final_r  <= 1'b0;
      len_ok_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      rnd_r    <= rnd_nxt;
      final_r  <= final_nxt;
      len_ok_r <= len_ok_nxt;
    end
  end

  `ASSERT_NXT(a_rounds_end, clk, rst_n, state_r == S_ROUND && rnd_r == RND_W'(ROUNDS - 1), state_r == S_UPDATE)
  `ASSERT_NXT(a_block_full, clk, rst_n, cmd.load_work, fill_r == '0 && rnd_r == '0)
  `ASSERT_IMP(a_digest_free, clk, rst_n, cmd.digest_load, !stat.out_busy && fill_r == '0)
  `ASSERT_IMP(a_len_slot, clk, rst_n, cmd.shift_en && cmd.byte_sel == SEL_LEN, fill_r >= LEN_START && final_r)
  `ASSERT_IMP(a_no_shift_in_rounds, clk, rst_n, state_r == S_ROUND, !cmd.shift_en && !in_tready)

endmodule

@@ sv/sha1_hash_engine.sv @@
// ----------------------------------------------------------------------------
// sha1_hash_engine
// absorb beat: shifts the byte in; the beat that fills a 64-byte block then
// runs 80 rounds on the single round unit plus the chaining-word update, and
// no byte is taken until they end; finish beat: padding bytes up to the block
// end, the rounds of each padded block (two when 56 or more bytes are pending),
// then the digest load; the digest leaves as 5 beats from the cycle after
// synchronous active-low reset restores the initial chaining words, length zero
// ----------------------------------------------------------------------------
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] kind: 0 absorb byte, 1 finish message
  // digest channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word, set on the fifth digest word
);
  import sha1_pkg::*;

  // commands from the sequencer, status back from the datapath
  cmd_t  cmd;
  stat_t stat;

  // the sequencer owns the byte and round counts and the input handshake;
  // a byte is taken only in idle, padding bytes are generated internally
  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser[0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  // the datapath holds the block window, working words, chaining words and a
  // five-word digest buffer, so a new message streams in while the digest drains
  sha1_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
